### rtl/core/sll_pkg.sv
`default_nettype none

package sll_pkg;

  // Fixed field widths of the two channels.
  localparam int unsigned POS_W  = 10;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned LEN_W  = 10;

  // Default number of slots in the backing store.
  localparam int unsigned SLOTS_DEF = 1024;

  // Operation codes carried in the mode field.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                    mode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_F,
    S_INS_F2,
    S_INS_FN,
    S_WALK,
    S_STEP,
    S_FIN,
    S_INS_LK,
    S_DEL_J,
    S_DEL_0,
    S_DEL_W
  } state_t;

endpackage

`default_nettype wire

### rtl/core/sll_ram.sv
`default_nettype none

module sll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same address return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/static_linked_list_engine_top.sv
`default_nettype none

// Static linked list engine. The list lives in a slot store: every slot holds
// a data word and a link to the next slot, slot 0 heads the free chain, the
// last slot heads the element list, and a link of zero ends a chain. An item
// is taken when start is high and busy is low; it inserts a value before a
// 1-based position or deletes the element at a position, and gives exactly
// one result beat on out_strobe, which stays high for one cycle only. The
// receiver cannot stall, so it must take every result in the cycle it is
// shown. A rejected position never raises busy, and its result shows in the
// next cycle. An insert or a delete holds busy for a walk along the list
// that grows with the position, and an insert into a full store holds it
// only until the free head is read. In every case the result beat shows in
// the first cycle with busy low, and a new item may be taken in that same
// cycle. Busy time is set by the walk along the links: one read of the link
// memory per hop, through its single registered read port. After reset a
// clearing pass over every slot rebuilds the free chain, with busy held high.
module static_linked_list_engine_top #(
  parameter int unsigned SLOTS = sll_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire sll_pkg::in_t  in_data,
  output logic             out_strobe,
  output sll_pkg::out_t    out_data
);

  import sll_pkg::*;

  localparam int unsigned AW   = $clog2(SLOTS);
  localparam int unsigned CMPW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam logic [AW-1:0] HEAD      = AW'(SLOTS - 1);
  localparam logic [AW-1:0] LAST_LINK = AW'(SLOTS - 2);

  state_t state_r, state_nxt;

  logic [AW-1:0]    clr_r, clr_nxt;
  logic [AW-1:0]    count_r, count_nxt;
  logic             mode_r, mode_nxt;
  logic [POS_W-1:0] steps_r, steps_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_r, out_nxt;

  // Link memory ports.
  logic          lk_we;
  logic [AW-1:0] lk_waddr;
  logic [AW-1:0] lk_wdata;
  logic [AW-1:0] lk_raddr;
  logic [AW-1:0] lk_rdata;

  // Data memory write port; its contents never reach a result.
  logic             dt_we;
  logic [AW-1:0]    dt_waddr;
  logic [VAL_W-1:0] dt_wdata;

  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic            pos_ok;

  sll_ram #(
    .WIDTH (AW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata),
    .rd_addr (lk_raddr),
    .rd_data (lk_rdata)
  );

  sll_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (dt_we),
    .wr_addr (dt_waddr),
    .wr_data (dt_wdata),
    .rd_addr ('0),
    .rd_data ()
  );

  // Position check against the element count: an insert may land one past
  // the last element, a delete must hit an existing one.
  assign pos_x = CMPW'(in_data.position);
  assign cnt_x = CMPW'(count_r);

  always_comb begin
    if (in_data.mode == MODE_INSERT) begin
      pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
    end else begin
      pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    steps_r <= steps_nxt;
    val_r   <= val_nxt;
    k_r     <= k_nxt;
    slot_r  <= slot_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    steps_nxt      = steps_r;
    val_nxt        = val_r;
    k_nxt          = k_r;
    slot_nxt       = slot_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;

    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    lk_raddr = '0;
    dt_we    = 1'b0;
    dt_waddr = slot_r;
    dt_wdata = val_r;

    case (state_r)
      S_CLEAR: begin
        // Chain every usable slot into the free list; the last two slots
        // end the free chain and the empty element list.
        lk_we    = 1'b1;
        lk_waddr = clr_r;
        lk_wdata = (clr_r < LAST_LINK) ? clr_r + AW'(1) : '0;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == HEAD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_data.mode;
          val_nxt   = in_data.value;
          steps_nxt = in_data.position - POS_W'(1);
          k_nxt     = HEAD;
          if (!pos_ok) begin
            out_strobe_nxt = 1'b1;
            out_nxt.status = ST_RANGE;
            out_nxt.slot   = '0;
            out_nxt.length = LEN_W'(count_r);
          end else if (in_data.mode == MODE_INSERT) begin
            state_nxt = S_INS_F;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_INS_F: begin
        lk_raddr  = '0;
        state_nxt = S_INS_F2;
      end

      S_INS_F2: begin
        // The head of the free chain has arrived.
        if (lk_rdata == '0) begin
          out_strobe_nxt = 1'b1;
          out_nxt.status = ST_FULL;
          out_nxt.slot   = '0;
          out_nxt.length = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = lk_rdata;
          lk_raddr  = lk_rdata;
          state_nxt = S_INS_FN;
        end
      end

      S_INS_FN: begin
        // Unhook the taken slot from the free chain and store the value.
        lk_we     = 1'b1;
        lk_waddr  = '0;
        lk_wdata  = lk_rdata;
        dt_we     = 1'b1;
        state_nxt = S_WALK;
      end

      S_WALK: begin
        lk_raddr = k_r;
        if (steps_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        // One hop per cycle: the link just read becomes the next address.
        k_nxt     = lk_rdata;
        lk_raddr  = lk_rdata;
        steps_nxt = steps_r - POS_W'(1);
        if (steps_r == POS_W'(1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // The link out of the predecessor has arrived.
        if (mode_r == MODE_INSERT) begin
          lk_we     = 1'b1;
          lk_waddr  = slot_r;
          lk_wdata  = lk_rdata;
          state_nxt = S_INS_LK;
        end else if (lk_rdata == '0 || lk_rdata == HEAD) begin
          out_strobe_nxt = 1'b1;
          out_nxt.status = ST_RANGE;
          out_nxt.slot   = '0;
          out_nxt.length = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          slot_nxt  = lk_rdata;
          lk_raddr  = lk_rdata;
          state_nxt = S_DEL_J;
        end
      end

      S_INS_LK: begin
        lk_we          = 1'b1;
        lk_waddr       = k_r;
        lk_wdata       = slot_r;
        count_nxt      = count_r + AW'(1);
        out_strobe_nxt = 1'b1;
        out_nxt.status = ST_OK;
        out_nxt.slot   = SLOT_W'(slot_r);
        out_nxt.length = LEN_W'(count_r + AW'(1));
        state_nxt      = S_IDLE;
      end

      S_DEL_J: begin
        // Bridge the predecessor over the victim, then fetch the free head.
        lk_we     = 1'b1;
        lk_waddr  = k_r;
        lk_wdata  = lk_rdata;
        lk_raddr  = '0;
        state_nxt = S_DEL_0;
      end

      S_DEL_0: begin
        lk_we     = 1'b1;
        lk_waddr  = slot_r;
        lk_wdata  = lk_rdata;
        state_nxt = S_DEL_W;
      end

      S_DEL_W: begin
        lk_we          = 1'b1;
        lk_waddr       = '0;
        lk_wdata       = slot_r;
        count_nxt      = count_r - AW'(1);
        out_strobe_nxt = 1'b1;
        out_nxt.status = ST_OK;
        out_nxt.slot   = SLOT_W'(slot_r);
        out_nxt.length = LEN_W'(count_r - AW'(1));
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire
